// File: src/ofdm_pilot_channel_equalizer_unit_assert.svh
// Assertion macros for the OFDM pilot channel equaliser.
// Clocked on i_clk and disabled while i_rst_n is low; no other dependencies.
`ifndef OFDM_PILOT_CHANNEL_EQUALIZER_UNIT_ASSERT_SVH
`define OFDM_PILOT_CHANNEL_EQUALIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define OPCE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define OPCE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OPCE_ASSERT_IMP(lbl, ante, cons, msg)
`define OPCE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/opce_pkg.sv
// Shared types and constants of the OFDM pilot channel equaliser.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none
package opce_pkg;
    typedef logic [1:0]        t_kind;
    typedef logic signed [5:0] t_sc;

    localparam t_kind KIND_START = 2'd0;
    localparam t_kind KIND_PILOT = 2'd1;
    localparam t_kind KIND_DATA  = 2'd2;

    localparam int OUT_WIDTH = 16;
    localparam int Q_BITS    = 16;
    localparam int FRAC_SHIFT = 11;

    localparam t_sc SC_MIN     = -6'sd26;
    localparam t_sc SC_MAX     = 6'sd26;
    localparam t_sc SC_PIL_N21 = -6'sd21;
    localparam t_sc SC_PIL_N7  = -6'sd7;
    localparam t_sc SC_PIL_P7  = 6'sd7;
    localparam t_sc SC_PIL_P21 = 6'sd21;
    localparam t_sc SC_EDGE_N  = -6'sd14;
    localparam t_sc SC_EDGE_P  = 6'sd14;
    localparam t_sc SC_DC      = 6'sd0;
endpackage
`default_nettype wire

// File: src/opce_if.sv
// Valid/ready channel interfaces for the equaliser's input and result requests.
// Depends on opce_pkg for the field types.
`default_nettype none
interface opce_in_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    opce_pkg::t_kind                kind;
    logic signed [SAMPLE_WIDTH-1:0] sample_re;
    logic signed [SAMPLE_WIDTH-1:0] sample_im;
    opce_pkg::t_sc                  subcarrier;
    modport source (output valid, kind, sample_re, sample_im, subcarrier, input ready);
    modport sink   (input valid, kind, sample_re, sample_im, subcarrier, output ready);
endinterface

interface opce_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [opce_pkg::OUT_WIDTH-1:0] eq_re;
    logic signed [opce_pkg::OUT_WIDTH-1:0] eq_im;
    opce_pkg::t_sc                         out_subcarrier;
    logic                                  estimate_zero;
    logic                                  saturated;
    modport source (output valid, eq_re, eq_im, out_subcarrier, estimate_zero, saturated,
                    input ready);
    modport sink   (input valid, eq_re, eq_im, out_subcarrier, estimate_zero, saturated,
                    output ready);
endinterface
`default_nettype wire

// File: src/ofdm_pilot_channel_equalizer_unit.sv
// OFDM pilot-based zero-forcing equaliser, 802.11a style.
// Input channel i_in carries requests: packet start, pilot sample or data sample.
// Output channel o_out carries one equalised Q5.10 symbol per usable data request.
// Packet start and pilot requests give no result.
// A data request runs through a shared multiplier (six products), a set-up
// step, a bit-serial divider for both parts and a step that forms the result;
// the next request is taken only after that.
// The divider loop takes one quotient bit per cycle.
// A zero estimate skips the divider.
// Data at DC, at a pilot position or beyond +/-26 is dropped.
// The result sits in an output register; new requests are taken while it waits.
// If the receiver stalls, a finished data request holds in its last state until
// the output register frees.
// Reset (synchronous, active low) clears the estimates, returns the scrambler
// to all ones and the pilot slot to zero; no clearing pass is needed.
// Depends on opce_pkg, opce_if and the assertion header.
`default_nettype none
`include "ofdm_pilot_channel_equalizer_unit_assert.svh"
module ofdm_pilot_channel_equalizer_unit #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int PILOT_COUNT  = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    opce_in_if.sink     i_in,
    opce_out_if.source  o_out
);
    import opce_pkg::*;

    localparam int W  = SAMPLE_WIDTH;
    localparam int PW = 2 * W;
    localparam int NW = 2 * W + 1;
    localparam int RW = 2 * W + Q_BITS + 1;
    localparam int SW = $clog2(PILOT_COUNT);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [Q_BITS-1:0] QPOS_MAX = {1'b0, {(Q_BITS-1){1'b1}}};
    localparam logic [Q_BITS-1:0] QNEG_MAX = {1'b1, {(Q_BITS-1){1'b0}}};

    logic [2:0]             r_state;
    logic [3:0]             r_cnt;
    logic signed [W-1:0]    r_est_re [PILOT_COUNT];
    logic signed [W-1:0]    r_est_im [PILOT_COUNT];
    logic [6:0]             r_scr;
    logic [SW-1:0]          r_slot;
    logic                   r_sign;
    logic signed [W-1:0]    r_yr, r_yi, r_hr, r_hi;
    t_sc                    r_sc;
    logic signed [PW-1:0]   r_prod;
    logic signed [NW-1:0]   r_den, r_nr, r_ni;
    logic [RW-1:0]          r_rem_r, r_rem_i, r_dsh;
    logic [Q_BITS-1:0]      r_q_r, r_q_i;
    logic                   r_neg_r, r_neg_i, r_ovf_r, r_ovf_i, r_zero;
    logic                   r_out_valid;
    logic signed [OUT_WIDTH-1:0] r_eq_re, r_eq_im;
    t_sc                    r_out_sc;
    logic                   r_out_zero, r_out_sat;

    logic                   accept, sc_ok, fb, pil_neg, out_free;
    logic [SW-1:0]          idx;
    logic signed [W-1:0]    op_a, op_b, pil_re, pil_im;
    logic signed [NW-1:0]   p_ext;
    logic [PW-1:0]          mag_r, mag_i, den_u;
    logic [RW-1:0]          num_r, num_i, dlim;
    logic                   sat_r, sat_i;
    logic signed [OUT_WIDTH-1:0] res_r, res_i;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    // Usable data subcarrier: in band, not DC, not a pilot
    always_comb begin
        sc_ok = (i_in.subcarrier >= SC_MIN) && (i_in.subcarrier <= SC_MAX);
        if (i_in.subcarrier inside {SC_DC, SC_PIL_N21, SC_PIL_N7, SC_PIL_P7, SC_PIL_P21}) begin
            sc_ok = 1'b0;
        end
    end

    // Nearest pilot region
    always_comb begin
        if (i_in.subcarrier <= SC_EDGE_N) begin
            idx = SW'(0);
        end else if (i_in.subcarrier < SC_DC) begin
            idx = SW'(1);
        end else if (i_in.subcarrier <= SC_EDGE_P) begin
            idx = SW'(2);
        end else begin
            idx = SW'(3);
        end
    end

    // Pilot reference sign, negation saturates the most negative code
    assign fb      = r_scr[6] ^ r_scr[3];
    assign pil_neg = ((r_slot == '0) ? fb : r_sign) ^ (r_slot == SW'(PILOT_COUNT - 1));
    assign pil_re  = !pil_neg ? i_in.sample_re : (i_in.sample_re == SMIN) ? SMAX : -i_in.sample_re;
    assign pil_im  = !pil_neg ? i_in.sample_im : (i_in.sample_im == SMIN) ? SMAX : -i_in.sample_im;

    // Operand select for the shared multiplier
    always_comb begin
        case (r_cnt[2:0])
            3'd0: begin op_a = r_hr; op_b = r_hr; end
            3'd1: begin op_a = r_hi; op_b = r_hi; end
            3'd2: begin op_a = r_yr; op_b = r_hr; end
            3'd3: begin op_a = r_yi; op_b = r_hi; end
            3'd4: begin op_a = r_yi; op_b = r_hr; end
            3'd5: begin op_a = r_yr; op_b = r_hi; end
            default: begin op_a = r_hr; op_b = r_hr; end
        endcase
    end
    assign p_ext = {r_prod[PW-1], r_prod};

    // Divider set-up: numerator mag*2048 + den, divisor 2*den
    assign mag_r = r_nr[NW-1] ? PW'(-r_nr) : PW'(r_nr);
    assign mag_i = r_ni[NW-1] ? PW'(-r_ni) : PW'(r_ni);
    assign den_u = PW'(r_den);
    assign num_r = (RW'(mag_r) << FRAC_SHIFT) + RW'(den_u);
    assign num_i = (RW'(mag_i) << FRAC_SHIFT) + RW'(den_u);
    assign dlim  = RW'(den_u) << (Q_BITS + 1);

    // Sign and clip of the quotients
    always_comb begin
        if (r_neg_r) begin
            sat_r = r_ovf_r || (r_q_r > QNEG_MAX);
            res_r = sat_r ? $signed(QNEG_MAX) : $signed(-r_q_r);
        end else begin
            sat_r = r_ovf_r || (r_q_r > QPOS_MAX);
            res_r = sat_r ? $signed(QPOS_MAX) : $signed(r_q_r);
        end
        if (r_neg_i) begin
            sat_i = r_ovf_i || (r_q_i > QNEG_MAX);
            res_i = sat_i ? $signed(QNEG_MAX) : $signed(-r_q_i);
        end else begin
            sat_i = r_ovf_i || (r_q_i > QPOS_MAX);
            res_i = sat_i ? $signed(QPOS_MAX) : $signed(r_q_i);
        end
    end

    // Control and estimate state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_scr       <= 7'h7F;
            r_slot      <= '0;
            r_sign      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < PILOT_COUNT; k++) begin
                r_est_re[k] <= '0;
                r_est_im[k] <= '0;
            end
        end else begin
            // Raise the result flag on a finished request, drop it once taken
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_in.kind)
                            KIND_START: begin
                                r_scr  <= 7'h7F;
                                r_slot <= '0;
                                r_sign <= 1'b0;
                                for (int k = 0; k < PILOT_COUNT; k++) begin
                                    r_est_re[k] <= '0;
                                    r_est_im[k] <= '0;
                                end
                            end
                            KIND_PILOT: begin
                                if (r_slot == '0) begin
                                    r_scr  <= {r_scr[5:0], fb};
                                    r_sign <= fb;
                                end
                                r_est_re[r_slot] <= pil_re;
                                r_est_im[r_slot] <= pil_im;
                                r_slot <= (r_slot == SW'(PILOT_COUNT - 1)) ? '0 : r_slot + 1'b1;
                            end
                            KIND_DATA: begin
                                if (sc_ok) begin
                                    r_state <= S_MUL;
                                    r_cnt   <= '0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd6) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_cnt   <= 4'(Q_BITS - 1);
                    r_state <= (r_den == '0) ? S_DONE : S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath: operand capture, products, long division, result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_yr <= i_in.sample_re;
            r_yi <= i_in.sample_im;
            r_sc <= i_in.subcarrier;
            r_hr <= r_est_re[idx];
            r_hi <= r_est_im[idx];
        end
        if (r_state == S_MUL) begin
            r_prod <= op_a * op_b;
            case (r_cnt)
                4'd1: r_den <= p_ext;
                4'd2: r_den <= r_den + p_ext;
                4'd3: r_nr  <= p_ext;
                4'd4: r_nr  <= r_nr + p_ext;
                4'd5: r_ni  <= p_ext;
                4'd6: r_ni  <= r_ni - p_ext;
                default: begin
                end
            endcase
        end
        if (r_state == S_PREP) begin
            r_zero  <= (r_den == '0);
            r_neg_r <= r_nr[NW-1];
            r_neg_i <= r_ni[NW-1];
            r_ovf_r <= (num_r >= dlim);
            r_ovf_i <= (num_i >= dlim);
            r_rem_r <= num_r;
            r_rem_i <= num_i;
            r_dsh   <= RW'(den_u) << Q_BITS;
        end
        if (r_state == S_DIV) begin
            if (r_rem_r >= r_dsh) begin
                r_rem_r <= r_rem_r - r_dsh;
            end
            if (r_rem_i >= r_dsh) begin
                r_rem_i <= r_rem_i - r_dsh;
            end
            r_q_r <= {r_q_r[Q_BITS-2:0], (r_rem_r >= r_dsh)};
            r_q_i <= {r_q_i[Q_BITS-2:0], (r_rem_i >= r_dsh)};
            r_dsh <= r_dsh >> 1;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_sc   <= r_sc;
            r_out_zero <= r_zero;
            r_eq_re    <= r_zero ? '0 : res_r;
            r_eq_im    <= r_zero ? '0 : res_i;
            r_out_sat  <= r_zero ? 1'b0 : (sat_r || sat_i);
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.eq_re          = r_eq_re;
    assign o_out.eq_im          = r_eq_im;
    assign o_out.out_subcarrier = r_out_sc;
    assign o_out.estimate_zero  = r_out_zero;
    assign o_out.saturated      = r_out_sat;

    `OPCE_ASSERT_IMP(a_zero_out, o_out.valid && o_out.estimate_zero, (o_out.eq_re == 0) && (o_out.eq_im == 0) && !o_out.saturated, "zero estimate with non-zero result")
    `OPCE_ASSERT_NXT(a_data_start, accept && (i_in.kind == KIND_DATA) && sc_ok, r_state == S_MUL, "usable data request did not start")
    `OPCE_ASSERT_IMP(a_scr_live, 1'b1, r_scr != 7'd0, "scrambler locked at zero")
    `OPCE_ASSERT_IMP(a_mul_cnt, r_state == S_MUL, r_cnt <= 4'd6, "multiplier step out of range")
endmodule
`default_nettype wire
